// ===== rtl/core/arbitrary_axis_point_rotation_core_defines.svh =====
`ifndef ARBITRARY_AXIS_POINT_ROTATION_CORE_DEFINES_SVH
`define ARBITRARY_AXIS_POINT_ROTATION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define AAPR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define AAPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/aapr_pkg.sv =====
`timescale 1ns / 1ps

package aapr_pkg;

    localparam int unsigned ADDR_W = 5;

    typedef enum logic [2:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_END_X   = 3'd3,
        CFG_END_Y   = 3'd4,
        CFG_END_Z   = 3'd5
    } cfg_idx_t;

    localparam logic [31:0] SIN_C0 = 32'd1686629713;
    localparam logic [31:0] SIN_C1 = 32'd693598668;
    localparam logic [31:0] SIN_C2 = 32'd85569306;
    localparam logic [31:0] SIN_C3 = 32'd5026995;
    localparam logic [31:0] SIN_C4 = 32'd172272;
    localparam logic [31:0] SIN_C5 = 32'd3864;

    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [69:0] ROUND_HALF = 70'h2000_0000;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] rr_xx;
        logic signed [31:0] rr_xy;
        logic signed [31:0] rr_xz;
        logic signed [31:0] rr_yy;
        logic signed [31:0] rr_yz;
        logic signed [31:0] rr_zz;
        logic               degen;
    } axis_coef_t;

    typedef struct packed {
        logic signed [33:0] v_x;
        logic signed [33:0] v_y;
        logic signed [33:0] v_z;
        logic signed [31:0] sn;
        logic signed [31:0] cs;
    } front_item_t;

    // a*b/2^30, rounded half away from zero
    function automatic logic signed [35:0] mulq(input logic signed [34:0] a,
                                                input logic signed [34:0] b);
        logic [34:0] ma;
        logic [34:0] mb;
        logic [69:0] p;
        logic [39:0] q;
        ma = a[34] ? 35'(-a) : 35'(a);
        mb = b[34] ? 35'(-b) : 35'(b);
        p  = 70'(ma) * 70'(mb);
        q  = 40'((p + ROUND_HALF) >> 30);
        mulq = (a[34] ^ b[34]) ? -36'(q) : 36'(q);
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [37:0] a);
        logic signed [37:0] hi;
        logic signed [37:0] lo;
        hi = $signed(38'(ONE_Q30));
        lo = -hi;
        if (a > hi) begin
            clamp_unit = 32'(hi);
        end else if (a < lo) begin
            clamp_unit = 32'(lo);
        end else begin
            clamp_unit = 32'(a);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] a);
        if (a > 38'sh0_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (a < -38'sh0_8000_0000) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = 32'(a);
        end
    endfunction

    function automatic logic [31:0] horner(input logic [31:0] c,
                                           input logic [30:0] z2,
                                           input logic [31:0] t);
        logic [62:0] p;
        p = 63'(z2) * 63'(t);
        horner = c - 32'(p >> 30);
    endfunction

endpackage

// ===== rtl/core/aapr_axis.sv =====
`timescale 1ns / 1ps
`include "arbitrary_axis_point_rotation_core_defines.svh"

module aapr_axis
    import aapr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output axis_coef_t        coef,
    output logic              busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SHIFT,
        ST_SQ,
        ST_ROOT,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_PAIR
    } state_t;

    state_t             state_reg;
    logic [31:0]        cfg_reg [6];
    logic [32:0]        a_reg [3];
    logic               neg_reg [3];
    logic signed [31:0] r_reg [3];
    logic signed [31:0] rr_reg [6];
    logic               degen_reg;
    logic [1:0]         idx_reg;
    logic [4:0]         cnt_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        x_reg;
    logic [33:0]        rem_reg;
    logic [31:0]        root_reg;
    logic [31:0]        drem_reg;
    logic [30:0]        numlo_reg;
    logic [30:0]        q_reg;

    cfg_idx_t           cfg_idx;
    logic               cfg_wr;
    logic signed [32:0] d_v [3];
    logic [32:0]        a_v [3];
    logic [32:0]        mx;
    logic [30:0]        a_sel;
    logic [61:0]        sq;
    logic [35:0]        rem_sh;
    logic [35:0]        trial;
    logic [61:0]        num;
    logic [32:0]        drem_sh;
    logic               qbit;
    logic [30:0]        q_fin;

    assign cfg_idx = cfg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (cfg_idx <= CFG_END_Z) ? cfg_reg[cfg_idx] : 32'd0;
    assign busy    = (state_reg != ST_IDLE);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_v[i] = $signed(33'($signed(cfg_reg[i + 3]))) - $signed(33'($signed(cfg_reg[i])));
            a_v[i] = d_v[i][32] ? 33'(-d_v[i]) : 33'(d_v[i]);
        end
        mx = a_reg[0];
        if (a_reg[1] > mx)
        begin
            mx = a_reg[1];
        end
        if (a_reg[2] > mx)
        begin
            mx = a_reg[2];
        end
        a_sel   = a_reg[idx_reg][30:0];
        sq      = 62'(a_sel) * 62'(a_sel);
        rem_sh  = {rem_reg, x_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        num     = (62'(a_sel) << 30) + 62'(root_reg[31:1]);
        drem_sh = {drem_reg, numlo_reg[30]};
        qbit    = (drem_sh >= {1'b0, root_reg});
        q_fin   = {q_reg[29:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            degen_reg <= 1'b1;
            for (int i = 0; i < 6; i++)
            begin
                cfg_reg[i] <= 32'd0;
                rr_reg[i]  <= 32'sd0;
            end
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i] <= 32'sd0;
            end
        end
        else
        begin
            if (cfg_wr && (cfg_idx <= CFG_END_Z))
            begin
                cfg_reg[cfg_idx] <= pwdata;
            end
            if (cfg_wr)
            begin
                state_reg <= ST_PREP;
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        state_reg <= ST_IDLE;
                    end
                    ST_PREP:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            a_reg[i]   <= a_v[i];
                            neg_reg[i] <= d_v[i][32];
                            r_reg[i]   <= 32'sd0;
                        end
                        if ((a_v[0] | a_v[1] | a_v[2]) == 33'd0)
                        begin
                            degen_reg <= 1'b1;
                            state_reg <= ST_PAIR;
                        end
                        else
                        begin
                            degen_reg <= 1'b0;
                            state_reg <= ST_SHIFT;
                        end
                    end
                    ST_SHIFT:
                    begin
                        if (mx[32] || mx[31])
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                a_reg[i] <= a_reg[i] >> 1;
                            end
                        end
                        else if (!mx[30])
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                a_reg[i] <= a_reg[i] << 1;
                            end
                        end
                        else
                        begin
                            idx_reg   <= 2'd0;
                            sum_reg   <= 64'd0;
                            state_reg <= ST_SQ;
                        end
                    end
                    ST_SQ:
                    begin
                        sum_reg <= sum_reg + 64'(sq);
                        if (idx_reg == 2'd2)
                        begin
                            x_reg     <= sum_reg + 64'(sq);
                            rem_reg   <= 34'd0;
                            root_reg  <= 32'd0;
                            cnt_reg   <= 5'd31;
                            state_reg <= ST_ROOT;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 2'd1;
                        end
                    end
                    ST_ROOT:
                    begin
                        x_reg <= x_reg << 2;
                        if (rem_sh >= trial)
                        begin
                            rem_reg  <= 34'(rem_sh - trial);
                            root_reg <= {root_reg[30:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= rem_sh[33:0];
                            root_reg <= {root_reg[30:0], 1'b0};
                        end
                        if (cnt_reg == 5'd0)
                        begin
                            idx_reg   <= 2'd0;
                            state_reg <= ST_DIV_LOAD;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - 5'd1;
                        end
                    end
                    ST_DIV_LOAD:
                    begin
                        drem_reg  <= 32'(num[61:31]);
                        numlo_reg <= num[30:0];
                        q_reg     <= 31'd0;
                        cnt_reg   <= 5'd30;
                        state_reg <= ST_DIV_STEP;
                    end
                    ST_DIV_STEP:
                    begin
                        numlo_reg <= numlo_reg << 1;
                        q_reg     <= q_fin;
                        if (qbit)
                        begin
                            drem_reg <= 32'(drem_sh - {1'b0, root_reg});
                        end
                        else
                        begin
                            drem_reg <= drem_sh[31:0];
                        end
                        if (cnt_reg == 5'd0)
                        begin
                            r_reg[idx_reg] <= neg_reg[idx_reg] ? -32'(q_fin) : 32'(q_fin);
                            if (idx_reg == 2'd2)
                            begin
                                state_reg <= ST_PAIR;
                            end
                            else
                            begin
                                idx_reg   <= idx_reg + 2'd1;
                                state_reg <= ST_DIV_LOAD;
                            end
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - 5'd1;
                        end
                    end
                    ST_PAIR:
                    begin
                        rr_reg[0] <= 32'(mulq(35'(r_reg[0]), 35'(r_reg[0])));
                        rr_reg[1] <= 32'(mulq(35'(r_reg[0]), 35'(r_reg[1])));
                        rr_reg[2] <= 32'(mulq(35'(r_reg[0]), 35'(r_reg[2])));
                        rr_reg[3] <= 32'(mulq(35'(r_reg[1]), 35'(r_reg[1])));
                        rr_reg[4] <= 32'(mulq(35'(r_reg[1]), 35'(r_reg[2])));
                        rr_reg[5] <= 32'(mulq(35'(r_reg[2]), 35'(r_reg[2])));
                        state_reg <= ST_IDLE;
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        coef.start_x = $signed(cfg_reg[CFG_START_X]);
        coef.start_y = $signed(cfg_reg[CFG_START_Y]);
        coef.start_z = $signed(cfg_reg[CFG_START_Z]);
        coef.r_x     = r_reg[0];
        coef.r_y     = r_reg[1];
        coef.r_z     = r_reg[2];
        coef.rr_xx   = rr_reg[0];
        coef.rr_xy   = rr_reg[1];
        coef.rr_xz   = rr_reg[2];
        coef.rr_yy   = rr_reg[3];
        coef.rr_yz   = rr_reg[4];
        coef.rr_zz   = rr_reg[5];
        coef.degen   = degen_reg;
    end

    `AAPR_ASSERT_NEXT(a_busy_after_write, cfg_wr, busy, "axis not recomputed after write")
    `AAPR_ASSERT_IMPL(a_degen_zero, !busy && degen_reg, (r_reg[0] == 32'sd0) && (r_reg[1] == 32'sd0) && (r_reg[2] == 32'sd0), "degenerate axis with non-zero direction")
    `AAPR_ASSERT_IMPL(a_unit_range, !busy, (r_reg[0] <= $signed(ONE_Q30)) && (r_reg[0] >= -$signed(ONE_Q30)), "axis component out of unit range")

endmodule

// ===== rtl/core/aapr_front.sv =====
`timescale 1ns / 1ps

module aapr_front
    import aapr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [15:0]        angle,
    input  axis_coef_t         coef,
    input  logic               busy,
    input  logic               fifo_full,
    output logic               push,
    output front_item_t        push_item
);

    typedef enum logic [1:0] {
        Q_FIRST,
        Q_SECOND,
        Q_THIRD,
        Q_FOURTH
    } quad_t;

    typedef struct packed {
        logic signed [33:0] v_x;
        logic signed [33:0] v_y;
        logic signed [33:0] v_z;
        quad_t              quad;
        logic [30:0]        zs;
        logic [30:0]        zc;
        logic [30:0]        z2s;
        logic [30:0]        z2c;
        logic [31:0]        ts;
        logic [31:0]        tc;
    } fstage_t;

    localparam int unsigned NST = 9;

    fstage_t     stg_reg [NST];
    fstage_t     stg_next [NST];
    logic        valid_reg [NST];
    logic        adv;
    logic [14:0] fc;
    logic [31:0] s0;
    logic [31:0] c0;

    assign adv         = !(valid_reg[NST-1] && fifo_full);
    assign point_ready = adv && !busy;
    assign push        = valid_reg[NST-1] && !fifo_full;

    always_comb
    begin
        stg_next[0]      = stg_reg[0];
        stg_next[0].v_x  = 34'($signed(point_x)) - 34'($signed(coef.start_x));
        stg_next[0].v_y  = 34'($signed(point_y)) - 34'($signed(coef.start_y));
        stg_next[0].v_z  = 34'($signed(point_z)) - 34'($signed(coef.start_z));
        stg_next[0].quad = quad_t'(angle[15:14]);
        fc               = 15'h4000 - 15'(angle[13:0]);
        stg_next[0].zs   = 31'({angle[13:0], 16'd0});
        stg_next[0].zc   = {fc, 16'd0};
        for (int k = 1; k < NST; k++)
        begin
            stg_next[k] = stg_reg[k-1];
        end
        stg_next[1].z2s = 31'((62'(stg_reg[0].zs) * 62'(stg_reg[0].zs)) >> 30);
        stg_next[1].z2c = 31'((62'(stg_reg[0].zc) * 62'(stg_reg[0].zc)) >> 30);
        stg_next[1].ts  = SIN_C5;
        stg_next[1].tc  = SIN_C5;
        stg_next[2].ts  = horner(SIN_C4, stg_reg[1].z2s, stg_reg[1].ts);
        stg_next[2].tc  = horner(SIN_C4, stg_reg[1].z2c, stg_reg[1].tc);
        stg_next[3].ts  = horner(SIN_C3, stg_reg[2].z2s, stg_reg[2].ts);
        stg_next[3].tc  = horner(SIN_C3, stg_reg[2].z2c, stg_reg[2].tc);
        stg_next[4].ts  = horner(SIN_C2, stg_reg[3].z2s, stg_reg[3].ts);
        stg_next[4].tc  = horner(SIN_C2, stg_reg[3].z2c, stg_reg[3].tc);
        stg_next[5].ts  = horner(SIN_C1, stg_reg[4].z2s, stg_reg[4].ts);
        stg_next[5].tc  = horner(SIN_C1, stg_reg[4].z2c, stg_reg[4].tc);
        stg_next[6].ts  = horner(SIN_C0, stg_reg[5].z2s, stg_reg[5].ts);
        stg_next[6].tc  = horner(SIN_C0, stg_reg[5].z2c, stg_reg[5].tc);
        stg_next[7].ts  = 32'((63'(stg_reg[6].zs) * 63'(stg_reg[6].ts)) >> 30);
        stg_next[7].tc  = 32'((63'(stg_reg[6].zc) * 63'(stg_reg[6].tc)) >> 30);
        s0 = (stg_reg[7].ts > ONE_Q30) ? ONE_Q30 : stg_reg[7].ts;
        c0 = (stg_reg[7].tc > ONE_Q30) ? ONE_Q30 : stg_reg[7].tc;
        unique case (stg_reg[7].quad)
            Q_FIRST:
            begin
                stg_next[8].ts = s0;
                stg_next[8].tc = c0;
            end
            Q_SECOND:
            begin
                stg_next[8].ts = c0;
                stg_next[8].tc = -s0;
            end
            Q_THIRD:
            begin
                stg_next[8].ts = -s0;
                stg_next[8].tc = -c0;
            end
            Q_FOURTH:
            begin
                stg_next[8].ts = -c0;
                stg_next[8].tc = s0;
            end
            default:
            begin
                stg_next[8].ts = s0;
                stg_next[8].tc = c0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= point_valid && point_ready;
            for (int k = 1; k < NST; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    always_comb
    begin
        push_item.v_x = stg_reg[NST-1].v_x;
        push_item.v_y = stg_reg[NST-1].v_y;
        push_item.v_z = stg_reg[NST-1].v_z;
        push_item.sn  = $signed(stg_reg[NST-1].ts);
        push_item.cs  = $signed(stg_reg[NST-1].tc);
    end

endmodule

// ===== rtl/core/aapr_fifo.sv =====
`timescale 1ns / 1ps
`include "arbitrary_axis_point_rotation_core_defines.svh"

module aapr_fifo
    import aapr_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_item,
    output logic        full,
    input  logic        pop,
    output front_item_t head,
    output logic        nonempty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    front_item_t      mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `AAPR_ASSERT_IMPL(a_push_room, push, !full, "push into full queue")
    `AAPR_ASSERT_IMPL(a_pop_data, pop, nonempty, "pop from empty queue")
    `AAPR_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a transaction")

endmodule

// ===== rtl/core/aapr_back.sv =====
`timescale 1ns / 1ps

module aapr_back
    import aapr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               nonempty,
    input  front_item_t        head,
    output logic               pop,
    input  axis_coef_t         coef,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] rotated_x,
    output logic signed [31:0] rotated_y,
    output logic signed [31:0] rotated_z,
    output logic               axis_degenerate
);

    logic signed [35:0] p_reg [6];
    logic signed [35:0] s_reg [3];
    logic signed [31:0] cs_reg;
    logic signed [33:0] v1_reg [3];
    logic signed [33:0] v2_reg [3];
    logic signed [31:0] m_reg [9];
    logic signed [35:0] t_reg [9];
    logic signed [31:0] rot_reg [3];
    logic               degen_reg;
    logic               b1_valid_reg;
    logic               b2_valid_reg;
    logic               b3_valid_reg;
    logic               out_valid_reg;

    logic               adv;
    logic signed [32:0] omc;
    logic signed [35:0] p_next [6];
    logic signed [35:0] s_next [3];
    logic signed [37:0] mm [9];
    logic signed [31:0] m_next [9];
    logic signed [35:0] t_next [9];
    logic signed [31:0] start_v [3];
    logic signed [37:0] acc [3];
    logic signed [31:0] rot_next [3];

    assign adv = !(out_valid_reg && !result_ready);
    assign pop = adv && nonempty;

    always_comb
    begin
        omc       = $signed(33'(ONE_Q30)) - 33'(head.cs);
        p_next[0] = mulq(35'(omc), 35'(coef.rr_xx));
        p_next[1] = mulq(35'(omc), 35'(coef.rr_xy));
        p_next[2] = mulq(35'(omc), 35'(coef.rr_xz));
        p_next[3] = mulq(35'(omc), 35'(coef.rr_yy));
        p_next[4] = mulq(35'(omc), 35'(coef.rr_yz));
        p_next[5] = mulq(35'(omc), 35'(coef.rr_zz));
        s_next[0] = mulq(35'(coef.r_x), 35'(head.sn));
        s_next[1] = mulq(35'(coef.r_y), 35'(head.sn));
        s_next[2] = mulq(35'(coef.r_z), 35'(head.sn));

        mm[0] = 38'(p_reg[0]) + 38'(cs_reg);
        mm[1] = 38'(p_reg[1]) - 38'(s_reg[2]);
        mm[2] = 38'(p_reg[2]) + 38'(s_reg[1]);
        mm[3] = 38'(p_reg[1]) + 38'(s_reg[2]);
        mm[4] = 38'(p_reg[3]) + 38'(cs_reg);
        mm[5] = 38'(p_reg[4]) - 38'(s_reg[0]);
        mm[6] = 38'(p_reg[2]) - 38'(s_reg[1]);
        mm[7] = 38'(p_reg[4]) + 38'(s_reg[0]);
        mm[8] = 38'(p_reg[5]) + 38'(cs_reg);
        for (int k = 0; k < 9; k++)
        begin
            m_next[k] = clamp_unit(mm[k]);
        end

        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                t_next[3*i+j] = mulq(35'(m_reg[3*i+j]), 35'(v2_reg[j]));
            end
        end

        start_v[0] = coef.start_x;
        start_v[1] = coef.start_y;
        start_v[2] = coef.start_z;
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = 38'(start_v[i]) + 38'(t_reg[3*i]) + 38'(t_reg[3*i+1])
                   + 38'(t_reg[3*i+2]);
            rot_next[i] = sat32(acc[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 6; k++)
            begin
                p_reg[k] <= p_next[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                s_reg[k]   <= s_next[k];
                v2_reg[k]  <= v1_reg[k];
                rot_reg[k] <= rot_next[k];
            end
            v1_reg[0] <= head.v_x;
            v1_reg[1] <= head.v_y;
            v1_reg[2] <= head.v_z;
            cs_reg    <= head.cs;
            for (int k = 0; k < 9; k++)
            begin
                m_reg[k] <= m_next[k];
                t_reg[k] <= t_next[k];
            end
            degen_reg <= coef.degen;
        end
    end

    assign result_valid    = out_valid_reg;
    assign rotated_x       = rot_reg[0];
    assign rotated_y       = rot_reg[1];
    assign rotated_z       = rot_reg[2];
    assign axis_degenerate = degen_reg;

endmodule

// ===== rtl/core/arbitrary_axis_point_rotation_core.sv =====
`timescale 1ns / 1ps
// Rotates Q16.16 points about the axis through two configured points by a
// 16-bit binary angle (65536 units per turn, anticlockwise).
// Configuration: APB-style port, six 32-bit registers at byte offsets 0..20
// (start x/y/z, end x/y/z); pready is always high, reads return the register.
// After each write the axis is renormalised by an iterative unit (shift
// normalise, three squares, a 32-step square root, three 31-step divides);
// point_ready stays low while it runs.
// Points: point_valid/point_ready, one transaction per cycle unless stalled.
// Results: result_valid/result_ready; an accepted point passes the nine
// front stages, the queue and then the four matrix stages.
// A nine-stage sine/cosine pipeline feeds a short queue that feeds a
// four-stage matrix pipeline; a stalled receiver holds the matrix side, the
// queue keeps taking points until it fills, then point_ready drops.
// Reset clears the axis registers: both axis points are zero, so the axis is
// degenerate and results are cos(angle) times the point.
module arbitrary_axis_point_rotation_core
    import aapr_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               point_valid,
    output logic               point_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [15:0]        angle,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] rotated_x,
    output logic signed [31:0] rotated_y,
    output logic signed [31:0] rotated_z,
    output logic               axis_degenerate
);

    axis_coef_t  coef;
    logic        busy;
    logic        fifo_full;
    logic        push;
    front_item_t push_item;
    logic        pop;
    front_item_t head;
    logic        nonempty;

    assign pready = 1'b1;

    aapr_axis u_axis (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .coef    (coef),
        .busy    (busy)
    );

    aapr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .angle       (angle),
        .coef        (coef),
        .busy        (busy),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_item   (push_item)
    );

    aapr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .head      (head),
        .nonempty  (nonempty)
    );

    aapr_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .nonempty        (nonempty),
        .head            (head),
        .pop             (pop),
        .coef            (coef),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .rotated_x       (rotated_x),
        .rotated_y       (rotated_y),
        .rotated_z       (rotated_z),
        .axis_degenerate (axis_degenerate)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import aapr_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               degen;
    } rotation_t;

    localparam longint ONE = 64'sd1 << 30;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               point_valid;
    logic               point_ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        angle;
    logic               result_valid;
    logic               result_ready;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               axis_degenerate;

    logic [31:0] axis_regs [6];
    rotation_t   pending_rotations [$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;

    arbitrary_axis_point_rotation_core uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .point_valid(point_valid), .point_ready(point_ready),
        .point_x(point_x), .point_y(point_y), .point_z(point_z), .angle(angle),
        .result_valid(result_valid), .result_ready(result_ready),
        .rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
        .axis_degenerate(axis_degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL arbitrary_axis_point_rotation_core");
        $finish;
    end

    function automatic longint sx32(logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint unsigned magnitude(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        longint unsigned p;
        p = (magnitude(a) * magnitude(b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint clamp_q30(longint a);
        if (a > ONE) return ONE;
        if (a < -ONE) return -ONE;
        return a;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned rem, root, bitv;
        rem = x;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint quarter_wave_sine(longint unsigned z);
        longint unsigned coef [6];
        longint unsigned z2, t;
        coef = '{1686629713, 693598668, 85569306, 5026995, 172272, 3864};
        z2 = (z * z) >> 30;
        t = coef[5];
        for (int k = 4; k >= 0; k--)
            t = coef[k] - ((z2 * t) >> 30);
        t = (z * t) >> 30;
        if (t > ONE) t = ONE;
        return longint'(t);
    endfunction

    function automatic rotation_t rotate_point(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz, logic [15:0] ang);
        longint d [3], v [3], r [3], m [3][3];
        longint unsigned a [3];
        longint unsigned mx, n, sum, f;
        longint sn, cs, omc, s0, c0, acc;
        logic [31:0] p [3];
        rotation_t res;
        p = '{px, py, pz};
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = sx32(axis_regs[i + 3]) - sx32(axis_regs[i]);
            v[i] = sx32(p[i]) - sx32(axis_regs[i]);
            a[i] = magnitude(d[i]);
            if (a[i] > mx) mx = a[i];
        end
        res.degen = (mx == 0);
        if (res.degen)
            r = '{0, 0, 0};
        else
        begin
            while (mx >= (64'd1 << 31))
            begin
                mx >>= 1;
                for (int i = 0; i < 3; i++) a[i] >>= 1;
            end
            while (mx < (64'd1 << 30))
            begin
                mx <<= 1;
                for (int i = 0; i < 3; i++) a[i] <<= 1;
            end
            sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            n = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                acc = longint'(((a[i] << 30) + (n >> 1)) / n);
                r[i] = d[i] < 0 ? -acc : acc;
            end
        end
        f = 64'(ang[13:0]);
        s0 = quarter_wave_sine(f << 16);
        c0 = quarter_wave_sine((64'h4000 - f) << 16);
        case (ang[15:14])
            2'd0: begin sn = s0;  cs = c0;  end
            2'd1: begin sn = c0;  cs = -s0; end
            2'd2: begin sn = -s0; cs = -c0; end
            default: begin sn = -c0; cs = s0; end
        endcase
        omc = ONE - cs;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = mul_q30(omc, mul_q30(r[i], r[j]));
        for (int i = 0; i < 3; i++) m[i][i] += cs;
        m[0][1] -= mul_q30(r[2], sn);
        m[0][2] += mul_q30(r[1], sn);
        m[1][0] += mul_q30(r[2], sn);
        m[1][2] -= mul_q30(r[0], sn);
        m[2][0] -= mul_q30(r[1], sn);
        m[2][1] += mul_q30(r[0], sn);
        for (int i = 0; i < 3; i++)
        begin
            acc = sx32(axis_regs[i]);
            for (int j = 0; j < 3; j++)
                acc += mul_q30(clamp_q30(m[i][j]), v[j]);
            if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
            if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
            p[i] = acc[31:0];
        end
        res.x = p[0];
        res.y = p[1];
        res.z = p[2];
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (recv_stall_pct == 0)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        rotation_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_rotations.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                e = pending_rotations.pop_front();
                if (rotated_x !== e.x)
                begin
                    $error("rotated_x expected %0d actual %0d", e.x, rotated_x);
                    errors++;
                end
                if (rotated_y !== e.y)
                begin
                    $error("rotated_y expected %0d actual %0d", e.y, rotated_y);
                    errors++;
                end
                if (rotated_z !== e.z)
                begin
                    $error("rotated_z expected %0d actual %0d", e.z, rotated_z);
                    errors++;
                end
                if (axis_degenerate !== e.degen)
                begin
                    $error("axis_degenerate expected %0d actual %0d", e.degen,
                           axis_degenerate);
                    errors++;
                end
            end
        end
    end

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [15:0] ang);
        if ($urandom_range(99) < send_idle_pct)
        begin
            point_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        point_valid <= 1'b1;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        angle <= ang;
        @(posedge clk);
        while (!point_ready) @(posedge clk);
        pending_rotations.insert(pending_rotations.size(), rotate_point(px, py, pz, ang));
    endtask

    task automatic drain();
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending_rotations.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr[ADDR_W-1:2] < 6) axis_regs[addr[ADDR_W-1:2]] = value;
        @(posedge clk);
    endtask

    task automatic set_axis(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
        drain();
        cfg_write({CFG_START_X, 2'b00}, sx);
        cfg_write({CFG_START_Y, 2'b00}, sy);
        cfg_write({CFG_START_Z, 2'b00}, sz);
        cfg_write({CFG_END_X, 2'b00}, ex);
        cfg_write({CFG_END_Y, 2'b00}, ey);
        cfg_write({CFG_END_Z, 2'b00}, ez);
    endtask

    function automatic logic [31:0] rand_coord(bit narrow);
        if (narrow) return 32'($signed($urandom_range(2097152)) - 1048576);
        return $urandom;
    endfunction

    task automatic send_extremes();
        logic [31:0] vals [5];
        logic [15:0] angs [7];
        vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'hFFFF_0000};
        angs = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000, 16'h3FFF};
        for (int i = 0; i < 7; i++)
            send_point(vals[i % 5], vals[(i + 1) % 5], vals[(i + 3) % 5], angs[i]);
    endtask

    task automatic test_reset_axis();
        send_extremes();
        send_point($urandom, $urandom, $urandom, 16'($urandom));
    endtask

    task automatic test_unit_axis();
        set_axis(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        send_extremes();
        set_axis(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_extremes();
    endtask

    task automatic test_extreme_axis();
        set_axis(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_extremes();
        set_axis(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF);
        send_extremes();
    endtask

    task automatic test_ignored_register();
        drain();
        cfg_write(5'd24, $urandom);
        cfg_write(5'd28, $urandom);
        send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 16'h1234);
    endtask

    task automatic test_random();
        logic [31:0] s [3];
        bit narrow;
        for (int k = 0; k < 8; k++)
        begin
            narrow = (k % 3) != 0;
            for (int i = 0; i < 3; i++) s[i] = rand_coord(narrow);
            if (k == 0)
                set_axis(s[0], s[1], s[2], s[0], s[1], s[2]);
            else
                set_axis(s[0], s[1], s[2], rand_coord(narrow), rand_coord(narrow),
                         rand_coord(narrow));
            case (k % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int n = 0; n < 215; n++)
            begin
                if (k == 2 && n == 100)
                begin
                    point_valid <= 1'b0;
                    @(posedge clk);
                    while (pending_rotations.size() != 0) @(posedge clk);
                end
                if ($urandom_range(3) == 0)
                    send_point(rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1),
                               16'($urandom));
                else
                    send_point($urandom, $urandom, $urandom, 16'($urandom));
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 6; i++) axis_regs[i] = 32'h0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        point_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        angle = '0;
        result_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (200) @(posedge clk);
        test_reset_axis();
        test_unit_axis();
        test_extreme_axis();
        test_ignored_register();
        test_random();
        drain();
        if (errors == 0)
            $display("PASS arbitrary_axis_point_rotation_core");
        else
            $display("FAIL arbitrary_axis_point_rotation_core");
        $finish;
    end

endmodule
